// ===== hw/rtl/hwtd_pkg.sv =====
// Shared types, constants and the CRC-8 helper for the humidity and temperature
// frame decoder. No dependencies; every other file in hw/rtl but hwtd_if imports this package.
package hwtd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TEMP_BAD = 2'd1;
  localparam logic [1:0] ST_HUM_BAD  = 2'd2;

  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [13:0] HUM_SPAN    = 14'd12500;
  localparam logic [13:0] HUM_OFFSET  = 14'd600;
  localparam logic [13:0] HUM_FULL    = 14'd10000;
  localparam logic [13:0] HUM_UPPER   = 14'd10600;

  typedef struct packed {
    logic        last;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic [1:0]  status;
  } hwtd_frm_t;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/hwtd_if.sv =====
// Valid/ready channel interfaces for reply bytes in and decoded results out.
// Depends on nothing beyond the base language.
interface hwtd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface hwtd_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic        [13:0] humidity_centi;
  logic        [15:0] temp_raw;
  logic        [15:0] hum_raw;
  logic        [1:0]  status;

  modport source (output valid, output temperature_centi, output humidity_centi,
                  output temp_raw, output hum_raw, output status, input ready);
  modport sink (input valid, input temperature_centi, input humidity_centi,
                input temp_raw, input hum_raw, input status, output ready);
endinterface

// ===== hw/rtl/hwtd_frame.sv =====
// Byte position tracking, word assembly and CRC checking for one sensor reply.
// Depends on hwtd_pkg for the CRC helper, status codes and the frame struct.
module hwtd_frame
  import hwtd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  output hwtd_frm_t  frm
);

  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  logic [2:0]  pos_r, pos_nxt, pos_eff;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] temp_word_r, temp_word_nxt;
  logic [15:0] hum_word_r, hum_word_nxt;
  logic        temp_bad_r, temp_bad_nxt;

  assign pos_eff = (frame_start || (pos_r > POS_H_CRC)) ? POS_T_MSB : pos_r;

  always_comb begin
    pos_nxt       = pos_eff + 3'd1;
    crc_nxt       = crc_r;
    temp_word_nxt = temp_word_r;
    hum_word_nxt  = hum_word_r;
    temp_bad_nxt  = temp_bad_r;
    unique case (pos_eff)
      POS_T_MSB: begin
        crc_nxt       = crc8_byte(CRC_INIT, rx_byte);
        temp_word_nxt = {rx_byte, 8'h00};
      end
      POS_T_LSB: begin
        crc_nxt       = crc8_byte(crc_r, rx_byte);
        temp_word_nxt = {temp_word_r[15:8], rx_byte};
      end
      POS_T_CRC: begin
        temp_bad_nxt = (crc_r != rx_byte);
        crc_nxt      = CRC_INIT;
      end
      POS_H_MSB: begin
        crc_nxt      = crc8_byte(CRC_INIT, rx_byte);
        hum_word_nxt = {rx_byte, 8'h00};
      end
      POS_H_LSB: begin
        crc_nxt      = crc8_byte(crc_r, rx_byte);
        hum_word_nxt = {hum_word_r[15:8], rx_byte};
      end
      default: begin
        pos_nxt = POS_T_MSB;
        crc_nxt = CRC_INIT;
      end
    endcase
  end

  always_comb begin
    frm.last      = (pos_eff == POS_H_CRC);
    frm.temp_word = temp_word_r;
    frm.hum_word  = hum_word_r;
    if (temp_bad_r) begin
      frm.status = ST_TEMP_BAD;
    end else if (crc_r != rx_byte) begin
      frm.status = ST_HUM_BAD;
    end else begin
      frm.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_T_MSB;
      crc_r       <= CRC_INIT;
      temp_word_r <= 16'h0000;
      hum_word_r  <= 16'h0000;
      temp_bad_r  <= 1'b0;
    end else if (fire) begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      temp_word_r <= temp_word_nxt;
      hum_word_r  <= hum_word_nxt;
      temp_bad_r  <= temp_bad_nxt;
    end
  end

endmodule

// ===== hw/rtl/hwtd_conv.sv =====
// Fixed-point conversion of the raw words to hundredths of a degree and percent.
// Depends on hwtd_pkg for the scale constants and status codes.
module hwtd_conv
  import hwtd_pkg::*;
(
  input  logic [15:0]        temp_word,
  input  logic [15:0]        hum_word,
  input  logic [1:0]         status,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi
);

  logic [31:0] temp_prod, temp_quo_full;
  logic [31:0] hum_prod, hum_quo_full;
  logic [14:0] temp_quo;
  logic [13:0] hum_quo;
  logic [15:0] temp_diff;

  // Division by 65535 is exact as (p + (p >> 16) + 1) >> 16 for every product p formed here.
  assign temp_prod     = 32'(temp_word) * 32'(TEMP_SPAN);
  assign temp_quo_full = (temp_prod + (temp_prod >> 16) + 32'd1) >> 16;
  assign temp_quo      = temp_quo_full[14:0];
  assign temp_diff     = 16'(temp_quo) - TEMP_OFFSET;

  assign hum_prod     = 32'(hum_word) * 32'(HUM_SPAN);
  assign hum_quo_full = (hum_prod + (hum_prod >> 16) + 32'd1) >> 16;
  assign hum_quo      = hum_quo_full[13:0];

  always_comb begin
    if (status != ST_OK) begin
      temperature_centi = 15'sd0;
      humidity_centi    = 14'd0;
    end else begin
      temperature_centi = signed'(temp_diff[14:0]);
      if (hum_quo < HUM_OFFSET) begin
        humidity_centi = 14'd0;
      end else if (hum_quo > HUM_UPPER) begin
        humidity_centi = HUM_FULL;
      end else begin
        humidity_centi = hum_quo - HUM_OFFSET;
      end
    end
  end

endmodule

// ===== hw/rtl/humidity_temp_frame_decoder.sv =====
// Top level of the humidity and temperature reply decoder.
// Depends on hwtd_pkg, the channel interfaces in hwtd_if, hwtd_frame and hwtd_conv.
//
// Feed the six reply bytes (temperature MSB, LSB, CRC, humidity MSB, LSB, CRC)
// as requests on the input channel, with frame_start set on the first byte;
// each data word is checked against its CRC-8 byte (polynomial 0x31, initial value 0xFF).
// The block takes one request per clock cycle, sustained while results are taken,
// because each byte passes once through the CRC update and the conversion
// multipliers between an input register and the result register. A result is
// registered as the sixth byte leaves the input register, and bytes keep flowing while
// a result waits to be taken, until the next sixth byte finds the result register full.
module humidity_temp_frame_decoder
  import hwtd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  hwtd_in_if.sink   in_ch,
  hwtd_out_if.source out_ch
);

  logic               in_vld_r;
  logic [7:0]         in_byte_r;
  logic               in_start_r;
  logic               out_free;
  logic               fire;
  hwtd_frm_t          frm;
  logic signed [14:0] temp_centi;
  logic [13:0]        hum_centi;

  logic               out_vld_r;
  logic signed [14:0] out_temp_r;
  logic [13:0]        out_hum_r;
  logic [15:0]        out_traw_r;
  logic [15:0]        out_hraw_r;
  logic [1:0]         out_status_r;

  assign out_free    = !out_vld_r || out_ch.ready;
  assign fire        = in_vld_r && (!frm.last || out_free);
  assign in_ch.ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r  <= in_ch.rx_byte;
      in_start_r <= in_ch.frame_start;
    end
  end

  hwtd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .rx_byte     (in_byte_r),
    .frame_start (in_start_r),
    .frm         (frm)
  );

  hwtd_conv u_conv (
    .temp_word         (frm.temp_word),
    .hum_word          (frm.hum_word),
    .status            (frm.status),
    .temperature_centi (temp_centi),
    .humidity_centi    (hum_centi)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && frm.last) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && frm.last) begin
      out_temp_r   <= temp_centi;
      out_hum_r    <= hum_centi;
      out_traw_r   <= frm.temp_word;
      out_hraw_r   <= frm.hum_word;
      out_status_r <= frm.status;
    end
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.temperature_centi = out_temp_r;
  assign out_ch.humidity_centi    = out_hum_r;
  assign out_ch.temp_raw          = out_traw_r;
  assign out_ch.hum_raw           = out_hraw_r;
  assign out_ch.status            = out_status_r;

endmodule
